>>> hdl/cts_pkg.sv
// Shared codes and control types for the completion slot tracker.
`default_nettype none

package cts_pkg;

	// Defaults for the top level parameters
	localparam int SLOT_COUNT_DEF    = 64;
	localparam int ADDRESS_WIDTH_DEF = 32;

	// Field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int KIND_W   = 2;
	localparam int IDX_W    = 6;
	localparam int WORD_W   = 32;
	localparam int RES_CAP  = 64;
	localparam int RCNT_W   = 7;

	// Request operations
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_COMPL   = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_SWEEP   = 2'd3;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_GRANT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NOFREE   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RECLAIM  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MISMATCH = 2'd3;

	// Control handed from the sequencer to the head update
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            slot_match;
		logic            granted;
		logic            cap_ok;
	} cts_ctl_t;

	// Result raised by the head update for the slot now at the head
	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] addr;
	} cts_hit_t;

endpackage

`default_nettype wire

>>> hdl/cts_cell.sv
// One slot cell of the rotating ring: valid mark, buffer address, completion word.
`default_nettype none

module cts_cell #(
	parameter int ADDRESS_WIDTH = cts_pkg::ADDRESS_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift,
	input  wire logic                        nxt_busy,
	input  wire logic [ADDRESS_WIDTH-1:0]    nxt_buf,
	input  wire logic [cts_pkg::WORD_W-1:0]  nxt_comp,
	output logic                             busy,
	output logic [ADDRESS_WIDTH-1:0]         buf_addr,
	output logic [cts_pkg::WORD_W-1:0]       comp
);

	logic                       busy_q;
	logic [ADDRESS_WIDTH-1:0]   buf_q;
	logic [cts_pkg::WORD_W-1:0] comp_q;

	// Advance the valid mark from the neighbour
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (shift) begin
			busy_q <= nxt_busy;
		end
	end

	// Advance the payload from the neighbour
	always_ff @(posedge clk) begin
		if (shift) begin
			buf_q  <= nxt_buf;
			comp_q <= nxt_comp;
		end
	end

	assign busy     = busy_q;
	assign buf_addr = buf_q;
	assign comp     = comp_q;

endmodule

`default_nettype wire

>>> hdl/cts_head.sv
// Update of the slot at the head of the ring for the request in progress.
`default_nettype none

module cts_head #(
	parameter int ADDRESS_WIDTH = cts_pkg::ADDRESS_WIDTH_DEF
) (
	input  wire cts_pkg::cts_ctl_t          ctl,
	input  wire logic [ADDRESS_WIDTH-1:0]   req_addr,
	input  wire logic [cts_pkg::WORD_W-1:0] req_word,
	input  wire logic                       cur_busy,
	input  wire logic [ADDRESS_WIDTH-1:0]   cur_buf,
	input  wire logic [cts_pkg::WORD_W-1:0] cur_comp,
	output logic                            new_busy,
	output logic [ADDRESS_WIDTH-1:0]        new_buf,
	output logic [cts_pkg::WORD_W-1:0]      new_comp,
	output cts_pkg::cts_hit_t               hit
);

	logic [cts_pkg::WORD_W-1:0] buf_low;

	// Low word of the stored address, zero-extended on narrow tables
	assign buf_low = cts_pkg::WORD_W'(cur_buf);

	// Apply the request to the head slot
	always_comb begin
		new_busy = cur_busy;
		new_buf  = cur_buf;
		new_comp = cur_comp;
		hit      = '0;
		unique case (ctl.op)
			cts_pkg::OP_ALLOC: begin
				if (!ctl.granted && !cur_busy) begin
					new_busy  = 1'b1;
					new_buf   = req_addr;
					new_comp  = '0;
					hit.valid = 1'b1;
					hit.kind  = cts_pkg::KIND_GRANT;
				end
			end
			cts_pkg::OP_COMPL: begin
				if (ctl.slot_match) begin
					new_comp = req_word;
				end
			end
			cts_pkg::OP_RELEASE: begin
				if (ctl.slot_match) begin
					new_busy = 1'b0;
					new_buf  = '0;
					new_comp = '0;
				end
			end
			cts_pkg::OP_SWEEP: begin
				if (cur_busy && (cur_comp != '0)) begin
					if (cur_comp == buf_low) begin
						// Matching word: free the slot and report its buffer
						new_busy  = 1'b0;
						new_buf   = '0;
						new_comp  = '0;
						hit.valid = ctl.cap_ok;
						hit.kind  = cts_pkg::KIND_RECLAIM;
						hit.addr  = buf_low;
					end else begin
						// Mismatch: keep the slot and report the word
						hit.valid = ctl.cap_ok;
						hit.kind  = cts_pkg::KIND_MISMATCH;
						hit.addr  = cur_comp;
					end
				end
			end
			default: begin
				hit = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/completion_slot_tracker.sv
// Top level of the completion slot tracker: slot ring, sequencer and result register.
//
//  channel   handshake              payload
//  request   start / busy           operation, buffer_address, slot_index, completion_word
//  result    strobe (one cycle)     kind, result_slot, result_address, last
//
// Each request makes one full rotation: the slot ring rotates once past the
// head update, one slot a cycle, then the flush state flushes the held result.
// A raised result waits until the next one is raised or the flush, and shows in the
// cycle after that; the final one carries last and shows in the cycle after the flush.
// Reset clears every valid mark at once, so the table reads as empty with no clearing pass.
// busy is high from acceptance until the flush cycle ends; the receiver cannot stall.
`default_nettype none

module completion_slot_tracker #(
	parameter int SLOT_COUNT    = cts_pkg::SLOT_COUNT_DEF,
	parameter int ADDRESS_WIDTH = cts_pkg::ADDRESS_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [cts_pkg::OP_W-1:0]     operation,
	input  wire logic [cts_pkg::WORD_W-1:0]   buffer_address,
	input  wire logic [cts_pkg::IDX_W-1:0]    slot_index,
	input  wire logic [cts_pkg::WORD_W-1:0]   completion_word,
	output logic                              strobe,
	output logic [cts_pkg::KIND_W-1:0]        kind,
	output logic [cts_pkg::IDX_W-1:0]         result_slot,
	output logic [cts_pkg::WORD_W-1:0]        result_address,
	output logic                              last
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CMP_W  = (SLOT_W > cts_pkg::IDX_W) ? SLOT_W : cts_pkg::IDX_W;
	localparam logic [SLOT_W-1:0] POS_LAST = SLOT_W'(SLOT_COUNT - 1);

	// Sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                  state_q;
	logic [SLOT_W-1:0]           pos_q;
	logic                        granted_q;
	logic [cts_pkg::RCNT_W-1:0]  res_cnt_q;
	logic [cts_pkg::OP_W-1:0]    op_q;
	logic [ADDRESS_WIDTH-1:0]    addr_q;
	logic [cts_pkg::IDX_W-1:0]   idx_q;
	logic [cts_pkg::WORD_W-1:0]  word_q;

	logic                        pend_valid_q;
	logic [cts_pkg::KIND_W-1:0]  pend_kind_q;
	logic [cts_pkg::IDX_W-1:0]   pend_slot_q;
	logic [cts_pkg::WORD_W-1:0]  pend_addr_q;

	logic                        strobe_q;
	logic [cts_pkg::KIND_W-1:0]  kind_q;
	logic [cts_pkg::IDX_W-1:0]   slot_q;
	logic [cts_pkg::WORD_W-1:0]  raddr_q;
	logic                        last_q;

	logic                        accept;
	logic                        shift;
	cts_pkg::cts_ctl_t           ctl;
	cts_pkg::cts_hit_t           hit;

	logic                        ring_busy [SLOT_COUNT];
	logic [ADDRESS_WIDTH-1:0]    ring_buf  [SLOT_COUNT];
	logic [cts_pkg::WORD_W-1:0]  ring_comp [SLOT_COUNT];
	logic                        head_busy;
	logic [ADDRESS_WIDTH-1:0]    head_buf;
	logic [cts_pkg::WORD_W-1:0]  head_comp;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign shift  = (state_q == ST_RUN);

	// Control for the head update
	assign ctl.op         = op_q;
	assign ctl.slot_match = (CMP_W'(idx_q) == CMP_W'(pos_q));
	assign ctl.granted    = granted_q;
	assign ctl.cap_ok     = (res_cnt_q < cts_pkg::RCNT_W'(cts_pkg::RES_CAP));

	cts_head #(
		.ADDRESS_WIDTH(ADDRESS_WIDTH)
	) u_head (
		.ctl      (ctl),
		.req_addr (addr_q),
		.req_word (word_q),
		.cur_busy (ring_busy[0]),
		.cur_buf  (ring_buf[0]),
		.cur_comp (ring_comp[0]),
		.new_busy (head_busy),
		.new_buf  (head_buf),
		.new_comp (head_comp),
		.hit      (hit)
	);

	// Ring of slot cells: each loads its neighbour, the tail loads the updated head
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == SLOT_COUNT - 1) begin : g_tail
			cts_cell #(
				.ADDRESS_WIDTH(ADDRESS_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.nxt_busy (head_busy),
				.nxt_buf  (head_buf),
				.nxt_comp (head_comp),
				.busy     (ring_busy[i]),
				.buf_addr (ring_buf[i]),
				.comp     (ring_comp[i])
			);
		end else begin : g_body
			cts_cell #(
				.ADDRESS_WIDTH(ADDRESS_WIDTH)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (shift),
				.nxt_busy (ring_busy[i+1]),
				.nxt_buf  (ring_buf[i+1]),
				.nxt_comp (ring_comp[i+1]),
				.busy     (ring_busy[i]),
				.buf_addr (ring_buf[i]),
				.comp     (ring_comp[i])
			);
		end
	end

	// Latch the request operands
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			addr_q <= ADDRESS_WIDTH'(buffer_address);
			idx_q  <= slot_index;
			word_q <= completion_word;
		end
	end

	// Sequence one rotation, then the flush cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pos_q     <= '0;
			granted_q <= 1'b0;
			res_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_RUN;
						pos_q     <= '0;
						granted_q <= 1'b0;
						res_cnt_q <= '0;
					end
				end
				ST_RUN: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == POS_LAST) begin
						state_q <= ST_FLUSH;
					end
					if (hit.valid) begin
						granted_q <= 1'b1;
						res_cnt_q <= res_cnt_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the latest result until the next one or the flush decides last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept || (state_q == ST_FLUSH)) begin
			pend_valid_q <= 1'b0;
		end else if (shift && hit.valid) begin
			pend_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift && hit.valid) begin
			pend_kind_q <= hit.kind;
			pend_slot_q <= cts_pkg::IDX_W'(pos_q);
			pend_addr_q <= hit.addr;
		end
	end

	// Drive the result strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (shift && hit.valid && pend_valid_q) ||
				((state_q == ST_FLUSH) && (pend_valid_q || (op_q == cts_pkg::OP_ALLOC)));
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FLUSH) && !pend_valid_q) begin
			// Allocate that found no free slot
			kind_q  <= cts_pkg::KIND_NOFREE;
			slot_q  <= '0;
			raddr_q <= '0;
			last_q  <= 1'b1;
		end else begin
			kind_q  <= pend_kind_q;
			slot_q  <= pend_slot_q;
			raddr_q <= pend_addr_q;
			last_q  <= (state_q == ST_FLUSH);
		end
	end

	assign strobe         = strobe_q;
	assign kind           = kind_q;
	assign result_slot    = slot_q;
	assign result_address = raddr_q;
	assign last           = last_q;

	// A result only follows a cycle of work
	a_strobe_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_RUN) || ($past(state_q) == ST_FLUSH))
		else $error("result strobe without a request in progress");

	// The final result comes only from the flush cycle
	a_last_from_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> ($past(state_q) == ST_FLUSH))
		else $error("last result outside the flush cycle");

	// A grant is only ever reported for an allocate
	a_grant_on_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (kind == cts_pkg::KIND_GRANT)) |-> (op_q == cts_pkg::OP_ALLOC))
		else $error("grant reported for another operation");

	// An accepted request starts its rotation at slot zero
	a_start_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (pos_q == '0))
		else $error("rotation did not start at slot zero");

	// The ring holds still outside a rotation
	a_ring_still: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |=> $stable(ring_busy[0]))
		else $error("slot ring moved while not rotating");

endmodule

`default_nettype wire
